### hdl/lrg_pkg.sv
package lrg_pkg;

  localparam int COORD_BITS       = 24;
  localparam int BASIS_BITS       = 16;
  localparam int ANGLE_ITERATIONS = 14;

  // Offset, product and projection widths.
  localparam int D_W    = COORD_BITS + 1;
  localparam int PROD_W = D_W + BASIS_BITS;
  localparam int PW     = PROD_W + 2;
  localparam int CW     = PW + 2;

  // Squared length and its square root, one result bit per step.
  localparam int SW       = 2 * D_W;
  localparam int SQ_STEPS = D_W;

  // Number of shared iteration stages.
  localparam int NST = (SQ_STEPS > ANGLE_ITERATIONS) ? SQ_STEPS : ANGLE_ITERATIONS;

  localparam int DIST_BITS = 26;
  localparam int AZ_BITS   = 16;
  localparam int ZW        = 24;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic signed [ZW-1:0] AZ_MAX    = 24'sd25736;
  localparam logic signed [ZW-1:0] PI_Z      = 24'sd3294199;
  localparam logic signed [ZW-1:0] HALF_PI_Z = 24'sd1647099;
  localparam int FAR_SHIFT = 26;

  // round(atan(2^-i) * 2^20)
  localparam logic [19:0] ATAN_TAB [20] = '{
    20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
    20'd16383, 20'd8192, 20'd4096, 20'd2048, 20'd1024, 20'd512, 20'd256,
    20'd128, 20'd64, 20'd32, 20'd16, 20'd8, 20'd4, 20'd2
  };

endpackage

### hdl/listener_relative_geometry.sv
// Relative geometry of one sound source seen from a listener. Each item gives
// the source position, the listener position and the listener's forward and
// right basis vectors; the block returns the rounded Euclidean distance of the
// offset (saturated at the top of its field), the azimuth atan2 of the right
// projection over the forward projection in Q2.13 radians, and a flag that is
// set when the source lies behind the listener. The block keeps no state and
// gives one result item per input item, in order. It is a fully pipelined
// datapath of 30 register stages: offset, products, sums, quadrant setup, 25
// shared iteration stages (one square-root bit and, in the first 14, one
// angle-rotation step each) and an output stage. A new item can be taken in
// every cycle in which stall_o is low. Each stage holds its item
// only while the stage after it is full and held, so bubbles are squeezed out
// when the output side stalls.
module listener_relative_geometry
  import lrg_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [COORD_BITS-1:0] source_x_i,
  input  logic signed [COORD_BITS-1:0] source_y_i,
  input  logic signed [COORD_BITS-1:0] source_z_i,
  input  logic signed [COORD_BITS-1:0] listener_x_i,
  input  logic signed [COORD_BITS-1:0] listener_y_i,
  input  logic signed [COORD_BITS-1:0] listener_z_i,
  input  logic signed [BASIS_BITS-1:0] forward_x_i,
  input  logic signed [BASIS_BITS-1:0] forward_y_i,
  input  logic signed [BASIS_BITS-1:0] forward_z_i,
  input  logic signed [BASIS_BITS-1:0] right_x_i,
  input  logic signed [BASIS_BITS-1:0] right_y_i,
  input  logic signed [BASIS_BITS-1:0] right_z_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [DIST_BITS-1:0]         distance_o,
  output logic signed [AZ_BITS-1:0]   azimuth_o,
  output logic                         behind_o
);

  localparam int NS = NST + 5;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  // A stage may load when it is empty or when the stage after it moves on.
  assign rdy[NS] = !stall_i;
  for (genvar j = 0; j < NS; j++) begin : g_rdy
    assign rdy[j] = !v_q[j] || rdy[j+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int j = 1; j < NS; j++) begin
        if (rdy[j]) begin
          v_q[j] <= v_q[j-1];
        end
      end
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = v_q[NS-1];

  // Stage 0: offsets; the basis vectors travel along.
  logic signed [D_W-1:0]        d_q [3];
  logic signed [BASIS_BITS-1:0] f_q [3];
  logic signed [BASIS_BITS-1:0] r_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      d_q[0] <= D_W'(source_x_i) - D_W'(listener_x_i);
      d_q[1] <= D_W'(source_y_i) - D_W'(listener_y_i);
      d_q[2] <= D_W'(source_z_i) - D_W'(listener_z_i);
      f_q[0] <= forward_x_i;
      f_q[1] <= forward_y_i;
      f_q[2] <= forward_z_i;
      r_q[0] <= right_x_i;
      r_q[1] <= right_y_i;
      r_q[2] <= right_z_i;
    end
  end

  // Stage 1: products and squares; the far check looks at each offset.
  logic signed [PROD_W-1:0] pfp_q [3];
  logic signed [PROD_W-1:0] prp_q [3];
  logic [SW-1:0]            sq_q  [3];
  logic                     far1_q;
  logic                     far1_d;
  logic signed [63:0]       dext  [3];

  always_comb begin
    far1_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dext[k] = 64'(d_q[k]);
      if (dext[k] >= (64'sd1 <<< FAR_SHIFT) || dext[k] <= -(64'sd1 <<< FAR_SHIFT)) begin
        far1_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int k = 0; k < 3; k++) begin
        pfp_q[k] <= PROD_W'(d_q[k] * f_q[k]);
        prp_q[k] <= PROD_W'(d_q[k] * r_q[k]);
        sq_q[k]  <= SW'($unsigned(SW'(d_q[k]) * SW'(d_q[k])));
      end
      far1_q <= far1_d;
    end
  end

  // Stage 2: projections and squared length.
  logic signed [PW-1:0] pf_q;
  logic signed [PW-1:0] pr_q;
  logic [SW-1:0]        s_q;
  logic                 far2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      pf_q   <= PW'(pfp_q[0]) + PW'(pfp_q[1]) + PW'(pfp_q[2]);
      pr_q   <= PW'(prp_q[0]) + PW'(prp_q[1]) + PW'(prp_q[2]);
      s_q    <= sq_q[0] + sq_q[1] + sq_q[2];
      far2_q <= far1_q;
    end
  end

  // Iteration state; index 0 is written by the quadrant setup stage.
  logic signed [CW-1:0] cx_q   [NST+1];
  logic signed [CW-1:0] cy_q   [NST+1];
  logic signed [ZW-1:0] cz_q   [NST+1];
  logic                 skip_q [NST+1];
  logic                 bh_q   [NST+1];
  logic                 far_q  [NST+1];
  logic [SW:0]          rx_q   [NST+1];
  logic [SW:0]          rr_q   [NST+1];

  // Stage 3: axis cases are settled here and skip the rotations; the left
  // half-plane is folded over with a start angle of plus or minus pi.
  logic signed [CW-1:0] pfe;
  logic signed [CW-1:0] pre;
  logic signed [CW-1:0] x0_d;
  logic signed [CW-1:0] y0_d;
  logic signed [ZW-1:0] z0_d;
  logic                 skip0_d;

  always_comb begin
    pfe     = CW'(pf_q);
    pre     = CW'(pr_q);
    x0_d    = pfe;
    y0_d    = pre;
    z0_d    = '0;
    skip0_d = 1'b0;
    if (pr_q == '0) begin
      skip0_d = 1'b1;
      z0_d    = (pf_q < 0) ? PI_Z : '0;
    end else if (pf_q == '0) begin
      skip0_d = 1'b1;
      z0_d    = (pr_q > 0) ? HALF_PI_Z : -HALF_PI_Z;
    end else if (pf_q < 0) begin
      x0_d = -pfe;
      y0_d = -pre;
      z0_d = (pr_q > 0) ? PI_Z : -PI_Z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      cx_q[0]   <= x0_d;
      cy_q[0]   <= y0_d;
      cz_q[0]   <= z0_d;
      skip_q[0] <= skip0_d;
      bh_q[0]   <= pf_q < 0;
      far_q[0]  <= far2_q;
      rx_q[0]   <= (SW+1)'(s_q);
      rr_q[0]   <= '0;
    end
  end

  // Shared iteration stages: one restoring square-root step and one CORDIC
  // vectoring step per stage, each only where its step count reaches.
  for (genvar k = 0; k < NST; k++) begin : g_iter
    logic [SW:0]          rx_d;
    logic [SW:0]          rr_d;
    logic signed [CW-1:0] cx_d;
    logic signed [CW-1:0] cy_d;
    logic signed [ZW-1:0] cz_d;

    if (k < SQ_STEPS) begin : g_sq
      localparam logic [SW:0] SQ_BIT = (SW+1)'(1) << (2 * (SQ_STEPS - 1 - k));
      logic [SW:0] trial;
      always_comb begin
        trial = rr_q[k] + SQ_BIT;
        if (rx_q[k] >= trial) begin
          rx_d = rx_q[k] - trial;
          rr_d = (rr_q[k] >> 1) + SQ_BIT;
        end else begin
          rx_d = rx_q[k];
          rr_d = rr_q[k] >> 1;
        end
      end
    end else begin : g_sq_pass
      assign rx_d = rx_q[k];
      assign rr_d = rr_q[k];
    end

    if (k < ANGLE_ITERATIONS) begin : g_rot
      localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[k]);
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      always_comb begin
        xs = cx_q[k] >>> k;
        ys = cy_q[k] >>> k;
        cx_d = cx_q[k];
        cy_d = cy_q[k];
        cz_d = cz_q[k];
        if (!skip_q[k]) begin
          if (cy_q[k] > 0) begin
            cx_d = cx_q[k] + ys;
            cy_d = cy_q[k] - xs;
            cz_d = cz_q[k] + ANG;
          end else begin
            cx_d = cx_q[k] - ys;
            cy_d = cy_q[k] + xs;
            cz_d = cz_q[k] - ANG;
          end
        end
      end
    end else begin : g_rot_pass
      assign cx_d = cx_q[k];
      assign cy_d = cy_q[k];
      assign cz_d = cz_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k+4]) begin
        cx_q[k+1]   <= cx_d;
        cy_q[k+1]   <= cy_d;
        cz_q[k+1]   <= cz_d;
        skip_q[k+1] <= skip_q[k];
        bh_q[k+1]   <= bh_q[k];
        far_q[k+1]  <= far_q[k];
        rx_q[k+1]   <= rx_d;
        rr_q[k+1]   <= rr_d;
      end
    end
  end

  // Output stage: round the root to nearest, saturate, and scale the angle
  // from 2^-20 rad down to Q2.13 with rounding and a clamp at plus or minus pi.
  logic [SW:0]          root;
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zc;
  logic [DIST_BITS-1:0] dist_q;
  logic signed [AZ_BITS-1:0] az_q;
  logic                 bhout_q;

  always_comb begin
    root = rr_q[NST] + ((rx_q[NST] > rr_q[NST]) ? (SW+1)'(1) : '0);
    zr   = (cz_q[NST] + ZW'(64)) >>> 7;
    zc   = zr;
    if (zr > AZ_MAX) begin
      zc = AZ_MAX;
    end else if (zr < -AZ_MAX) begin
      zc = -AZ_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      dist_q  <= (far_q[NST] || root > (SW+1)'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(root);
      az_q    <= AZ_BITS'(zc);
      bhout_q <= bh_q[NST];
    end
  end

  assign distance_o = dist_q;
  assign azimuth_o  = az_q;
  assign behind_o   = bhout_q;

endmodule
